// File: hw/rtl/kpc_pkg.sv
// Shared types, constants and helpers for the keyword presence counter.
// No dependencies; imported by every module of the block.
`default_nettype none

package kpc_pkg;

  localparam int MAX_WORD_LEN = 8;
  localparam int NUM_WORDS    = 6;

  // Slots visible on the config port and in the result beat.
  localparam int KW_SLOTS  = 6;
  localparam int WORD_W    = 64;
  localparam int LEN_W     = 4;
  localparam int LENS_W    = KW_SLOTS * LEN_W;
  localparam int COUNT_W   = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;

  // Window of preceding bytes; kept one byte wide when no history is needed.
  localparam int WIN_BYTES = (MAX_WORD_LEN > 1) ? MAX_WORD_LEN - 1 : 1;
  localparam int WIN_W     = 8 * WIN_BYTES;
  localparam int FILL_W    = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(MAX_WORD_LEN - 1);

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_WORD_0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTHS  = 3'd6;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       chunk_end;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count_a;
    logic [COUNT_W-1:0] count_b;
    logic [COUNT_W-1:0] count_c;
    logic [COUNT_W-1:0] count_d;
    logic [COUNT_W-1:0] count_e;
    logic [COUNT_W-1:0] count_f;
  } out_item_t;

  typedef struct packed {
    logic [KW_SLOTS-1:0][WORD_W-1:0] words;
    logic [KW_SLOTS-1:0][LEN_W-1:0]  lens;
  } cfg_t;

  function automatic logic [7:0] fold_case(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= 8'h41 && b <= 8'h5a) r = b + 8'h20;
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/kpc_cfg.sv
// Configuration register file: six keyword words and the packed lengths.
// Depends on kpc_pkg.
`default_nettype none

module kpc_cfg (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [kpc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [kpc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output kpc_pkg::cfg_t                       cfg_o
);
  import kpc_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      if (cfg_index_i < CFG_LENGTHS) begin
        cfg_d.words[cfg_index_i - CFG_WORD_0] = cfg_data_i[WORD_W-1:0];
      end else if (cfg_index_i == CFG_LENGTHS) begin
        cfg_d.lens = cfg_data_i[LENS_W-1:0];
      end
      // other indexes fall through untouched
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: hw/rtl/kpc_matcher.sv
// Compare of one keyword against the current byte and the byte window.
// Pure combinational; depends on kpc_pkg.
`default_nettype none

module kpc_matcher (
  input  wire logic [kpc_pkg::WORD_W-1:0] word_i,
  input  wire logic [kpc_pkg::LEN_W-1:0]  len_i,
  input  wire logic [7:0]                 cur_i,
  input  wire logic [kpc_pkg::WIN_W-1:0]  window_i,
  input  wire logic [kpc_pkg::FILL_W-1:0] fill_i,
  output logic                            hit_o
);
  import kpc_pkg::*;

  logic [MAX_WORD_LEN-1:0][7:0] probe;
  logic [MAX_WORD_LEN-1:0][7:0] kw;

  // probe byte k is the byte k positions back; probe[0] is the current one
  always_comb begin
    probe[0] = cur_i;
    for (int k = 1; k < MAX_WORD_LEN; k++) begin
      probe[k] = window_i[8*(k-1) +: 8];
    end
    for (int k = 0; k < MAX_WORD_LEN; k++) begin
      kw[k] = word_i[8*k +: 8];
    end
  end

  // one candidate per length; lengths outside 1..MAX never select
  always_comb begin
    logic ok;
    hit_o = 1'b0;
    for (int l = 1; l <= MAX_WORD_LEN; l++) begin
      ok = (int'(fill_i) >= l - 1);
      for (int k = 0; k < l; k++) begin
        if (kw[l-1-k] != probe[k]) ok = 1'b0;
      end
      if (len_i == LEN_W'(l) && ok) hit_o = 1'b1;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/keyword_presence_counter.sv
// Top level: input register, keyword matchers, chunk state and result register.
// Depends on kpc_pkg, kpc_cfg and kpc_matcher.
//
//   channel  dir  handshake            payload
//   in       in   in_valid_i/in_stall_o    kpc_pkg::in_item_t  (byte, chunk end)
//   out      out  out_valid_o/out_stall_i  kpc_pkg::out_item_t (six counts)
//   cfg      in   cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//
// One byte per cycle sustained while no chunk-end byte waits. A byte is held in
// the input register, where all keyword compares run in parallel; a chunk-end
// beat is then registered in the result register. Reset clears window, flags and
// counters. Only a chunk-end byte waits, and only while the result register is
// full and stalled; that back-pressure reaches in_stall_o in the same cycle.
`default_nettype none

module keyword_presence_counter (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire kpc_pkg::in_item_t              in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output kpc_pkg::out_item_t                  out_data_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [kpc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [kpc_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import kpc_pkg::*;

  cfg_t cfg;

  in_item_t                    in_q;
  logic                        in_vld_q, in_vld_d;
  logic [WIN_W-1:0]            window_q, window_d;
  logic [FILL_W-1:0]           fill_q, fill_d;
  logic [KW_SLOTS-1:0]         seen_q, seen_d;
  logic [KW_SLOTS-1:0][COUNT_W-1:0] counts_q, counts_d;
  out_item_t                   out_q;
  logic                        out_vld_q, out_vld_d;

  logic [7:0]          cur;
  logic [KW_SLOTS-1:0] hits;
  logic [KW_SLOTS-1:0] seen_new;
  logic                retire;
  logic                accept;
  logic [WIN_W+7:0]    shifted;

  kpc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign cur = fold_case(in_q.char_byte);

  for (genvar w = 0; w < KW_SLOTS; w++) begin : g_word
    if (w < NUM_WORDS) begin : g_on
      kpc_matcher u_match (
        .word_i   (cfg.words[w]),
        .len_i    (cfg.lens[w]),
        .cur_i    (cur),
        .window_i (window_q),
        .fill_i   (fill_q),
        .hit_o    (hits[w])
      );
    end else begin : g_off
      assign hits[w] = 1'b0;
    end
  end

  // a chunk-end byte needs a free result slot to retire
  assign retire     = in_vld_q && (!in_q.chunk_end || !out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !retire;
  assign accept     = in_valid_i && !in_stall_o;

  assign seen_new = seen_q | hits;
  assign shifted  = {window_q, cur};

  always_comb begin
    in_vld_d  = in_vld_q;
    window_d  = window_q;
    fill_d    = fill_q;
    seen_d    = seen_q;
    counts_d  = counts_q;
    out_vld_d = out_vld_q && out_stall_i;

    if (accept) begin
      in_vld_d = 1'b1;
    end else if (retire) begin
      in_vld_d = 1'b0;
    end

    if (retire) begin
      if (in_q.chunk_end) begin
        for (int w = 0; w < KW_SLOTS; w++) begin
          counts_d[w] = counts_q[w] + COUNT_W'(seen_new[w]);
        end
        seen_d    = '0;
        window_d  = '0;
        fill_d    = '0;
        out_vld_d = 1'b1;
      end else begin
        seen_d   = seen_new;
        window_d = shifted[WIN_W-1:0];
        if (fill_q < FILL_MAX) fill_d = fill_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      window_q  <= '0;
      fill_q    <= '0;
      seen_q    <= '0;
      counts_q  <= '0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      window_q  <= window_d;
      fill_q    <= fill_d;
      seen_q    <= seen_d;
      counts_q  <= counts_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (accept) in_q <= in_data_i;
    if (retire && in_q.chunk_end) begin
      out_q.count_a <= counts_d[0];
      out_q.count_b <= counts_d[1];
      out_q.count_c <= counts_d[2];
      out_q.count_d <= counts_d[3];
      out_q.count_e <= counts_d[4];
      out_q.count_f <= counts_d[5];
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
